@@ design/esa_pkg.sv @@
// Shared types and constants of the entity slot allocator.
// Used by the front, back, top level and checker; depends on nothing.
package esa_pkg;

   localparam int SLOT_COUNT    = 512;
   localparam int SLOT_BITS     = 9;
   localparam int PTR_BITS      = 10;
   localparam int MAP_ENTRIES   = 16;
   localparam int POS_BITS      = 4;
   localparam int LEN_BITS      = 5;
   localparam int KIND_BITS     = 8;
   localparam int REF_BITS      = 16;
   localparam int TYPE_BITS     = 3;
   localparam int STATUS_BITS   = 3;
   localparam int MAP_ADDR_BITS = SLOT_BITS + POS_BITS;
   localparam int QUEUE_DEPTH   = 2;
   localparam int REQ_DATA_BITS = 40;
   localparam int RSP_DATA_BITS = 40;

   typedef enum logic [TYPE_BITS-1:0] {
      REQ_CREATE  = 3'd0,
      REQ_DESTROY = 3'd1,
      REQ_LINK    = 3'd2,
      REQ_RELINK  = 3'd3,
      REQ_UNLINK  = 3'd4,
      REQ_GET     = 3'd5
   } req_code_type;

   typedef enum logic [2:0] {
      OP_CREATE,
      OP_DESTROY,
      OP_LINK,
      OP_RELINK,
      OP_UNLINK,
      OP_GET,
      OP_NOP
   } op_type;

   typedef enum logic [STATUS_BITS-1:0] {
      STAT_OK        = 3'd0,
      STAT_POOL_FULL = 3'd1,
      STAT_BAD_SLOT  = 3'd2,
      STAT_NOT_FOUND = 3'd3,
      STAT_PRESENT   = 3'd4,
      STAT_MAP_FULL  = 3'd5
   } status_type;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_CREATE,
      ST_CRT_WR,
      ST_DESTROY,
      ST_DST_END,
      ST_LEN_RD,
      ST_SEARCH,
      ST_ACT,
      ST_UNL_WR,
      ST_DONE
   } state_type;

   typedef struct packed {
      op_type               op;
      logic [SLOT_BITS-1:0] slot;
      logic [KIND_BITS-1:0] kind;
      logic [REF_BITS-1:0]  cref;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } queue_out_type;

   typedef struct packed {
      logic pop;
      logic init_done;
   } back_ctl_type;

endpackage

@@ design/entity_slot_allocator_component_map.sv @@
// Slot allocator with a FIFO free list and a per-slot component map. After
// reset the block initializes the free-list links and map lengths of all 512
// slots, and takes no request beat until that pass ends. Requests are queued
// (two deep) and then run one at a time by a sequencer over single-port
// memories. How long link, relink, get and unlink take is set by the map
// search, which reads one map entry per cycle over up to 16 entries of the
// addressed slot.
// A finished result waits in an output register while the next beat is taken.
module entity_slot_allocator_component_map (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // req_type[2:0], slot_id[11:3], comp_kind[19:12], comp_ref[35:20]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // status[2:0], handle[11:3], found_ref[27:12], live_count[37:28]
);

   esa_pkg::queue_out_type queue_out;
   esa_pkg::back_ctl_type  back_ctl;

   esa_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .back_ctl   (back_ctl),
      .queue_out  (queue_out)
   );

   esa_back u_back (
      .clock      (clock),
      .reset      (reset),
      .queue_out  (queue_out),
      .back_ctl   (back_ctl),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

@@ design/esa_front.sv @@
// Front of the slot allocator: accepts request beats, classifies them and
// holds them in a short queue. Depends on esa_pkg.
module esa_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [esa_pkg::REQ_DATA_BITS-1:0]   req_tdata,
   input  esa_pkg::back_ctl_type               back_ctl,
   output esa_pkg::queue_out_type              queue_out
);

   esa_pkg::cmd_type q_ff [esa_pkg::QUEUE_DEPTH];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       cnt_ff, cnt_in;
   esa_pkg::cmd_type cmd;
   logic             push;

   always_comb begin
      cmd.slot = req_tdata[11:3];
      cmd.kind = req_tdata[19:12];
      cmd.cref = req_tdata[35:20];
      case (req_tdata[2:0])
         esa_pkg::REQ_CREATE:  cmd.op = esa_pkg::OP_CREATE;
         esa_pkg::REQ_DESTROY: cmd.op = esa_pkg::OP_DESTROY;
         esa_pkg::REQ_LINK:    cmd.op = esa_pkg::OP_LINK;
         esa_pkg::REQ_RELINK:  cmd.op = esa_pkg::OP_RELINK;
         esa_pkg::REQ_UNLINK:  cmd.op = esa_pkg::OP_UNLINK;
         esa_pkg::REQ_GET:     cmd.op = esa_pkg::OP_GET;
         default:              cmd.op = esa_pkg::OP_NOP;
      endcase
   end

   assign req_tready = back_ctl.init_done && (cnt_ff != 2'(esa_pkg::QUEUE_DEPTH));
   assign push       = req_tvalid && req_tready;

   assign queue_out.valid = (cnt_ff != 2'd0);
   assign queue_out.cmd   = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ back_ctl.pop;
      cnt_in    = cnt_ff + 2'(push) - 2'(back_ctl.pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= cmd;
      end
   end

endmodule

@@ design/esa_back.sv @@
// Back of the slot allocator: free-list and slot-map memories, the request
// sequencer and the result register. Depends on esa_pkg.
module esa_back (
   input  logic                                clock,
   input  logic                                reset,
   input  esa_pkg::queue_out_type              queue_out,
   output esa_pkg::back_ctl_type               back_ctl,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [esa_pkg::RSP_DATA_BITS-1:0]   rsp_tdata
);

   localparam logic [esa_pkg::PTR_BITS-1:0] SlotEnd = esa_pkg::PTR_BITS'(esa_pkg::SLOT_COUNT);
   localparam logic [esa_pkg::LEN_BITS-1:0] MapMax  = esa_pkg::LEN_BITS'(esa_pkg::MAP_ENTRIES);

   logic [esa_pkg::PTR_BITS-1:0]  nf_mem   [esa_pkg::SLOT_COUNT];
   logic [esa_pkg::LEN_BITS-1:0]  len_mem  [esa_pkg::SLOT_COUNT];
   logic [esa_pkg::KIND_BITS-1:0] kind_mem [esa_pkg::SLOT_COUNT*esa_pkg::MAP_ENTRIES];
   logic [esa_pkg::REF_BITS-1:0]  ref_mem  [esa_pkg::SLOT_COUNT*esa_pkg::MAP_ENTRIES];

   logic                              nf_we, nf_re, len_we, len_re, kind_we, ref_we, map_re;
   logic [esa_pkg::SLOT_BITS-1:0]     nf_addr, len_addr;
   logic [esa_pkg::PTR_BITS-1:0]      nf_wdata, nf_rd_ff;
   logic [esa_pkg::LEN_BITS-1:0]      len_wdata, len_rd_ff;
   logic [esa_pkg::MAP_ADDR_BITS-1:0] map_addr;
   logic [esa_pkg::KIND_BITS-1:0]     kind_wdata, kind_rd_ff;
   logic [esa_pkg::REF_BITS-1:0]      ref_wdata, ref_rd_ff;

   esa_pkg::state_type  state_ff, state_in;
   esa_pkg::cmd_type    cur_ff, cur_in;
   esa_pkg::status_type status_ff, status_in;
   logic [esa_pkg::SLOT_BITS-1:0] cnt_ff, cnt_in, handle_ff, handle_in;
   logic [esa_pkg::PTR_BITS-1:0]  head_ff, head_in, tail_ff, tail_in, live_ff, live_in;
   logic [esa_pkg::LEN_BITS-1:0]  idx_ff, idx_in;
   logic [esa_pkg::POS_BITS-1:0]  ppos_ff, ppos_in, pos_ff, pos_in;
   logic                          pend_ff, pend_in, hit_ff, hit_in;
   logic [esa_pkg::REF_BITS-1:0]  found_ff, found_in, found_out;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [esa_pkg::RSP_DATA_BITS-1:0] rsp_data_ff, rsp_data_in;
   logic                          search_hit, out_free;
   logic [esa_pkg::LEN_BITS-1:0]  last_len;

   assign search_hit = pend_ff && (kind_rd_ff == cur_ff.kind);
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign last_len   = len_rd_ff - 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      found_out = '0;
      if (status_ff == esa_pkg::STAT_OK &&
          (cur_ff.op == esa_pkg::OP_GET || cur_ff.op == esa_pkg::OP_UNLINK)) begin
         found_out = found_ff;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         esa_pkg::ST_INIT: begin
            if (cnt_ff == esa_pkg::SLOT_BITS'(esa_pkg::SLOT_COUNT - 1)) state_in = esa_pkg::ST_IDLE;
         end
         esa_pkg::ST_IDLE: begin
            if (queue_out.valid) begin
               case (queue_out.cmd.op)
                  esa_pkg::OP_CREATE:  state_in = esa_pkg::ST_CREATE;
                  esa_pkg::OP_DESTROY: state_in = esa_pkg::ST_DESTROY;
                  esa_pkg::OP_NOP:     state_in = esa_pkg::ST_DONE;
                  default:             state_in = esa_pkg::ST_LEN_RD;
               endcase
            end
         end
         esa_pkg::ST_CREATE: begin
            if (live_ff >= SlotEnd || head_ff >= SlotEnd) state_in = esa_pkg::ST_DONE;
            else state_in = esa_pkg::ST_CRT_WR;
         end
         esa_pkg::ST_CRT_WR:  state_in = esa_pkg::ST_DONE;
         esa_pkg::ST_DESTROY: begin
            if (live_ff == '0) state_in = esa_pkg::ST_DONE;
            else state_in = esa_pkg::ST_DST_END;
         end
         esa_pkg::ST_DST_END: state_in = esa_pkg::ST_DONE;
         esa_pkg::ST_LEN_RD:  state_in = esa_pkg::ST_SEARCH;
         esa_pkg::ST_SEARCH: begin
            if (search_hit || idx_ff >= len_rd_ff) state_in = esa_pkg::ST_ACT;
         end
         esa_pkg::ST_ACT: begin
            if (cur_ff.op == esa_pkg::OP_UNLINK && hit_ff) state_in = esa_pkg::ST_UNL_WR;
            else state_in = esa_pkg::ST_DONE;
         end
         esa_pkg::ST_UNL_WR: state_in = esa_pkg::ST_DONE;
         esa_pkg::ST_DONE: begin
            if (out_free) state_in = esa_pkg::ST_IDLE;
         end
         default: state_in = esa_pkg::ST_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      nf_we = 1'b0; nf_re = 1'b0; nf_addr = cur_ff.slot; nf_wdata = SlotEnd;
      len_we = 1'b0; len_re = 1'b0; len_addr = cur_ff.slot; len_wdata = '0;
      kind_we = 1'b0; ref_we = 1'b0; map_re = 1'b0;
      map_addr = {cur_ff.slot, idx_ff[esa_pkg::POS_BITS-1:0]};
      kind_wdata = cur_ff.kind; ref_wdata = cur_ff.cref;
      back_ctl.pop = 1'b0;
      back_ctl.init_done = (state_ff != esa_pkg::ST_INIT);
      cur_in = cur_ff; status_in = status_ff; cnt_in = cnt_ff; handle_in = handle_ff;
      head_in = head_ff; tail_in = tail_ff; live_in = live_ff;
      idx_in = idx_ff; ppos_in = ppos_ff; pos_in = pos_ff; pend_in = pend_ff;
      hit_in = hit_ff; found_in = found_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;
      case (state_ff)
         esa_pkg::ST_INIT: begin
            nf_we = 1'b1; nf_addr = cnt_ff; nf_wdata = {1'b0, cnt_ff} + 1'b1;
            len_we = 1'b1; len_addr = cnt_ff;
            cnt_in = cnt_ff + 1'b1;
         end
         esa_pkg::ST_IDLE: begin
            if (queue_out.valid) begin
               back_ctl.pop = 1'b1;
               cur_in = queue_out.cmd;
               status_in = esa_pkg::STAT_OK;
               handle_in = queue_out.cmd.slot;
            end
         end
         esa_pkg::ST_CREATE: begin
            if (live_ff >= SlotEnd || head_ff >= SlotEnd) begin
               status_in = esa_pkg::STAT_POOL_FULL;
               handle_in = '0;
            end else begin
               nf_re = 1'b1; nf_addr = head_ff[esa_pkg::SLOT_BITS-1:0];
            end
         end
         esa_pkg::ST_CRT_WR: begin
            handle_in = head_ff[esa_pkg::SLOT_BITS-1:0];
            head_in = nf_rd_ff;
            live_in = live_ff + 1'b1;
            len_we = 1'b1; len_addr = head_ff[esa_pkg::SLOT_BITS-1:0];
         end
         esa_pkg::ST_DESTROY: begin
            if (live_ff == '0) begin
               status_in = esa_pkg::STAT_BAD_SLOT;
            end else if (live_ff >= SlotEnd) begin
               head_in = {1'b0, cur_ff.slot};
            end else if (tail_ff < SlotEnd) begin
               nf_we = 1'b1; nf_addr = tail_ff[esa_pkg::SLOT_BITS-1:0];
               nf_wdata = {1'b0, cur_ff.slot};
            end
         end
         esa_pkg::ST_DST_END: begin
            nf_we = 1'b1;
            tail_in = {1'b0, cur_ff.slot};
            live_in = live_ff - 1'b1;
         end
         esa_pkg::ST_LEN_RD: begin
            len_re = 1'b1;
            idx_in = '0; pend_in = 1'b0; hit_in = 1'b0;
         end
         esa_pkg::ST_SEARCH: begin
            if (search_hit) begin
               hit_in = 1'b1; pos_in = ppos_ff; found_in = ref_rd_ff; pend_in = 1'b0;
            end else if (idx_ff < len_rd_ff) begin
               map_re = 1'b1;
               pend_in = 1'b1;
               ppos_in = idx_ff[esa_pkg::POS_BITS-1:0];
               idx_in = idx_ff + 1'b1;
            end else begin
               pend_in = 1'b0;
            end
         end
         esa_pkg::ST_ACT: begin
            case (cur_ff.op)
               esa_pkg::OP_LINK: begin
                  if (hit_ff) begin
                     status_in = esa_pkg::STAT_PRESENT;
                  end else if (len_rd_ff >= MapMax) begin
                     status_in = esa_pkg::STAT_MAP_FULL;
                  end else begin
                     kind_we = 1'b1; ref_we = 1'b1;
                     map_addr = {cur_ff.slot, len_rd_ff[esa_pkg::POS_BITS-1:0]};
                     len_we = 1'b1; len_wdata = len_rd_ff + 1'b1;
                  end
               end
               esa_pkg::OP_RELINK: begin
                  if (!hit_ff) status_in = esa_pkg::STAT_NOT_FOUND;
                  else begin
                     ref_we = 1'b1; map_addr = {cur_ff.slot, pos_ff};
                  end
               end
               esa_pkg::OP_UNLINK: begin
                  if (!hit_ff) status_in = esa_pkg::STAT_NOT_FOUND;
                  else begin
                     map_re = 1'b1;
                     map_addr = {cur_ff.slot, last_len[esa_pkg::POS_BITS-1:0]};
                  end
               end
               default: begin
                  if (!hit_ff) status_in = esa_pkg::STAT_NOT_FOUND;
               end
            endcase
         end
         esa_pkg::ST_UNL_WR: begin
            kind_we = 1'b1; ref_we = 1'b1;
            map_addr = {cur_ff.slot, pos_ff};
            kind_wdata = kind_rd_ff; ref_wdata = ref_rd_ff;
            len_we = 1'b1; len_wdata = last_len;
         end
         esa_pkg::ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = {2'b0, live_ff, found_out, handle_ff, status_ff};
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= esa_pkg::ST_INIT;
         cnt_ff       <= '0;
         head_ff      <= '0;
         tail_ff      <= SlotEnd - 1'b1;
         live_ff      <= '0;
         pend_ff      <= 1'b0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         live_ff      <= live_in;
         pend_ff      <= pend_in;
         hit_ff       <= hit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      status_ff   <= status_in;
      handle_ff   <= handle_in;
      idx_ff      <= idx_in;
      ppos_ff     <= ppos_in;
      pos_ff      <= pos_in;
      found_ff    <= found_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (nf_we) nf_mem[nf_addr] <= nf_wdata;
      if (nf_re) nf_rd_ff <= nf_mem[nf_addr];
   end

   always_ff @(posedge clock) begin
      if (len_we) len_mem[len_addr] <= len_wdata;
      if (len_re) len_rd_ff <= len_mem[len_addr];
   end

   always_ff @(posedge clock) begin
      if (kind_we) kind_mem[map_addr] <= kind_wdata;
      if (map_re) kind_rd_ff <= kind_mem[map_addr];
   end

   always_ff @(posedge clock) begin
      if (ref_we) ref_mem[map_addr] <= ref_wdata;
      if (map_re) ref_rd_ff <= ref_mem[map_addr];
   end

endmodule

@@ design/esa_checker.sv @@
// Port-level checks for the slot allocator, bound to the top level.
// Depends on esa_pkg.
module esa_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [39:0] req_tdata,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result beat changed while stalled");

   a_live_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[37:28] <= 10'(esa_pkg::SLOT_COUNT))
      else $error("live count above pool size");

   a_full_handle: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2:0] == esa_pkg::STAT_POOL_FULL |-> rsp_tdata[11:3] == '0)
      else $error("pool full with nonzero handle");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[2:0] <= esa_pkg::STAT_MAP_FULL)
      else $error("undefined status code");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && !req_tready)
      else $error("busy right after reset");

endmodule

bind entity_slot_allocator_component_map esa_checker u_esa_checker (.*);
